// ===== design/ncst_pkg.sv =====
// Package for the named counting semaphore table: request and response types, codes, limits.
package ncst_pkg;

	localparam int SEM_ID_W    = 8;
	localparam int KEY_W       = 64;
	localparam int NAME_LEN_W  = 8;
	localparam int INIT_W      = 16;
	localparam int COUNT_W     = 17;
	localparam int WAITERS_W   = 8;
	localparam int RSP_ID_W    = 5;
	localparam int STATUS_W    = 2;

	localparam int NUM_SEMS_DEF       = 32;
	localparam logic [NAME_LEN_W-1:0] NAME_LIMIT_RST = 8'd25;

	localparam logic signed [COUNT_W-1:0] COUNT_MAX   = 17'sd65535;
	localparam logic signed [COUNT_W-1:0] COUNT_MIN   = -17'sd65536;
	localparam logic [WAITERS_W-1:0]      WAITERS_MAX = 8'd255;

	typedef enum logic [1:0] {
		OP_OPEN    = 2'd0,
		OP_ACQUIRE = 2'd1,
		OP_RELEASE = 2'd2,
		OP_CLOSE   = 2'd3
	} op_t;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic [1:0]               op;
		logic [SEM_ID_W-1:0]      sem_id;
		logic [KEY_W-1:0]         name_key;
		logic [NAME_LEN_W-1:0]    name_length;
		logic signed [INIT_W-1:0] initial_count;
	} ncst_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [RSP_ID_W-1:0] result_id;
		logic                must_block;
		logic                wake_one;
		logic                wake_all;
	} ncst_rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]          key;
		logic signed [COUNT_W-1:0] count;
		logic [WAITERS_W-1:0]      waiters;
	} ncst_entry_t;

endpackage

// ===== design/ncst_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module ncst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/named_counting_semaphore_table_top.sv =====
// Top level of the named counting semaphore table: request decode, key scan and entry update.
//
//  channel   signals                          direction  moves
//  cfg       cfg_wr_en, cfg_wr_data           in         name length limit
//  in        in_valid, in_stall, in_data      in         one request (ncst_req_t)
//  out       out_valid, out_stall, out_data   out        one response (ncst_rsp_t)
//
// One request at a time. Open scans the entry RAM one entry per cycle through its single
// read port; acquire, release and close read and update the addressed entry, and a rejected
// request is answered directly. Reset clears the in-use bits at once, no clearing pass.
// A stalled response holds the block in its final state until the response register frees.
module named_counting_semaphore_table_top #(
	parameter int NUM_SEMS = ncst_pkg::NUM_SEMS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [ncst_pkg::NAME_LEN_W-1:0] cfg_wr_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  ncst_pkg::ncst_req_t             in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output ncst_pkg::ncst_rsp_t             out_data
);
	import ncst_pkg::*;

	localparam int ID_W = $clog2(NUM_SEMS);
	localparam logic [ID_W-1:0] LAST_ID = ID_W'(NUM_SEMS - 1);
	localparam logic [SEM_ID_W:0] NUM_SEMS_EXT = (SEM_ID_W + 1)'(NUM_SEMS);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_MOD  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t                 st_q;
	logic [NAME_LEN_W-1:0]  name_limit_q;
	logic [NUM_SEMS-1:0]    in_use_q;
	ncst_req_t              req_q;
	ncst_rsp_t              res_q;
	logic [ID_W-1:0]        cnt_q;
	logic                   issue_q;
	logic                   rd_vld_s1;
	logic [ID_W-1:0]        idx_s1;
	logic                   free_found_q;
	logic [ID_W-1:0]        free_idx_q;
	logic                   out_valid_q;
	ncst_rsp_t              out_data_q;

	logic                   in_acc;
	logic                   id_ok;
	logic                   open_ok;
	logic [ID_W-1:0]        in_idx;
	logic [ID_W-1:0]        req_idx;
	logic                   ram_we;
	logic [ID_W-1:0]        ram_waddr;
	ncst_entry_t            ram_wdata;
	logic                   ram_re;
	logic [ID_W-1:0]        ram_raddr;
	ncst_entry_t            ram_rdata;
	logic                   hit;
	logic                   slot_found;
	logic [ID_W-1:0]        slot_idx;
	logic                   out_load;
	ncst_entry_t            upd;
	ncst_rsp_t              mod_rsp;
	ncst_rsp_t              acc_rsp;
	ncst_rsp_t              scan_rsp;

	assign in_stall  = (st_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign in_idx    = in_data.sem_id[ID_W-1:0];
	assign req_idx   = req_q.sem_id[ID_W-1:0];
	assign id_ok     = ({1'b0, in_data.sem_id} < NUM_SEMS_EXT) && in_use_q[in_idx];
	assign open_ok   = (in_data.name_length != '0) && (in_data.name_length <= name_limit_q)
		&& !in_data.initial_count[INIT_W-1];

	assign hit        = rd_vld_s1 && in_use_q[idx_s1] && (ram_rdata.key == req_q.name_key);
	assign slot_found = free_found_q || !in_use_q[idx_s1];
	assign slot_idx   = free_found_q ? free_idx_q : idx_s1;
	assign out_load   = (st_q == S_DONE) && (!out_valid_q || !out_stall);

	// start every request as invalid; scan or update overwrite it
	always_comb begin
		acc_rsp        = '0;
		acc_rsp.status = ST_INVALID;
		if (in_data.op != OP_OPEN) begin
			acc_rsp.result_id = in_data.sem_id[RSP_ID_W-1:0];
		end
	end

	// open outcome at a hit or at the last scanned entry
	always_comb begin
		scan_rsp        = '0;
		scan_rsp.status = ST_OK;
		if (hit) begin
			scan_rsp.result_id = RSP_ID_W'(idx_s1);
		end else if (slot_found) begin
			scan_rsp.result_id = RSP_ID_W'(slot_idx);
		end else begin
			scan_rsp.status = ST_FULL;
		end
	end

	// read port: entry of the addressed id at accept, scan address during open
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = cnt_q;
		if (st_q == S_IDLE) begin
			ram_re    = in_acc && (in_data.op != OP_OPEN);
			ram_raddr = in_idx;
		end else if (st_q == S_SCAN) begin
			ram_re    = issue_q;
		end
	end

	// update of an entry for acquire, release and close
	always_comb begin
		upd                = ram_rdata;
		mod_rsp            = '0;
		mod_rsp.status     = ST_OK;
		mod_rsp.result_id  = req_q.sem_id[RSP_ID_W-1:0];
		case (req_q.op)
			OP_ACQUIRE: begin
				if (ram_rdata.count != COUNT_MIN) begin
					upd.count = ram_rdata.count - 17'sd1;
				end
				mod_rsp.must_block = upd.count[COUNT_W-1];
				if (upd.count[COUNT_W-1] && (ram_rdata.waiters != WAITERS_MAX)) begin
					upd.waiters = ram_rdata.waiters + 8'd1;
				end
			end
			OP_RELEASE: begin
				if (ram_rdata.count != COUNT_MAX) begin
					upd.count = ram_rdata.count + 17'sd1;
				end
				mod_rsp.wake_one = (ram_rdata.waiters != '0);
				if (ram_rdata.waiters != '0) begin
					upd.waiters = ram_rdata.waiters - 8'd1;
				end
			end
			default: begin
				mod_rsp.wake_all = (ram_rdata.waiters != '0);
				upd.waiters      = '0;
			end
		endcase
	end

	// write port: new entry at the end of an open scan, or write back the updated entry of an acquire or release
	always_comb begin
		ram_we            = 1'b0;
		ram_waddr         = req_idx;
		ram_wdata         = upd;
		if (st_q == S_SCAN) begin
			ram_we            = rd_vld_s1 && !hit && (idx_s1 == LAST_ID) && slot_found;
			ram_waddr         = slot_idx;
			ram_wdata.key     = req_q.name_key;
			ram_wdata.count   = {1'b0, req_q.initial_count};
			ram_wdata.waiters = '0;
		end else if (st_q == S_MOD) begin
			ram_we            = (req_q.op != OP_CLOSE);
		end
	end

	ncst_ram #(
		.WIDTH ($bits(ncst_entry_t)),
		.DEPTH (NUM_SEMS)
	) u_entry_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			name_limit_q <= NAME_LIMIT_RST;
			in_use_q     <= '0;
			cnt_q        <= '0;
			issue_q      <= 1'b0;
			rd_vld_s1    <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				name_limit_q <= cfg_wr_data;
			end
			rd_vld_s1 <= (st_q == S_SCAN) && issue_q;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (in_acc) begin
						cnt_q        <= '0;
						issue_q      <= 1'b1;
						free_found_q <= 1'b0;
						if (in_data.op == OP_OPEN) begin
							st_q <= open_ok ? S_SCAN : S_DONE;
						end else begin
							st_q <= id_ok ? S_MOD : S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (issue_q) begin
						cnt_q <= cnt_q + 1'b1;
					end
					// stop issuing after the last entry or at a hit
					if ((issue_q && (cnt_q == LAST_ID)) || hit) begin
						issue_q <= 1'b0;
					end
					if (rd_vld_s1) begin
						if (!free_found_q && !in_use_q[idx_s1]) begin
							free_found_q <= 1'b1;
						end
						if (hit || (idx_s1 == LAST_ID)) begin
							st_q    <= S_DONE;
						end
						if (ram_we) begin
							in_use_q[slot_idx] <= 1'b1;
						end
					end
				end
				S_MOD: begin
					if (req_q.op == OP_CLOSE) begin
						in_use_q[req_idx] <= 1'b0;
					end
					st_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (out_load) begin
			out_data_q <= res_q;
		end
		case (st_q)
			S_IDLE: begin
				if (in_acc) begin
					req_q <= in_data;
					res_q <= acc_rsp;
				end
			end
			S_SCAN: begin
				if (rd_vld_s1) begin
					if (!free_found_q && !in_use_q[idx_s1]) begin
						free_idx_q <= idx_s1;
					end
					if (hit || (idx_s1 == LAST_ID)) begin
						res_q <= scan_rsp;
					end
				end
			end
			S_MOD: begin
				res_q <= mod_rsp;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted request did not block the input");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (st_q == S_SCAN) || (st_q == S_MOD))
		else $error("entry RAM written outside scan or update");

	a_claim_marks: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && (st_q == S_SCAN) |=> in_use_q[$past(ram_waddr)])
		else $error("claimed entry not marked in use");

	a_scan_read: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(st_q == S_SCAN))
		else $error("scan data without a scan read");

	a_done_load: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_DONE) && !$past(st_q == S_DONE) && !out_valid_q |=> out_valid_q)
		else $error("response not loaded into a free output register");

endmodule
